// ----- design/stmts_pkg.sv -----
// ----------------------------------------------------------------------------
// stmts_pkg
// Shared types and constants of the stepper move-to-sensor core.
// ----------------------------------------------------------------------------
`default_nettype none

package stmts_pkg;

  // Width of the phase accumulator and the tick counters.
  localparam int unsigned ACC_W = 32;

  // Quotient bits produced by the ramp divider, one per cycle.
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic [2:0] REG_PEAK_SPEED     = 3'd0;
  localparam logic [2:0] REG_BASE_SPEED     = 3'd1;
  localparam logic [2:0] REG_TARGET_TICKS   = 3'd2;
  localparam logic [2:0] REG_FAULT_THRESH   = 3'd3;
  localparam logic [2:0] REG_DECEL_TICKS    = 3'd4;
  localparam logic [2:0] REG_INVERT_DIR     = 3'd5;
  localparam logic [2:0] REG_SENSOR_LEVEL   = 3'd6;

  // Move outcome codes.
  localparam logic [1:0] OUTCOME_SUCCESS = 2'd0;
  localparam logic [1:0] OUTCOME_ABORTED = 2'd1;
  localparam logic [1:0] OUTCOME_FAULT   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_DECEL
  } move_phase_t;

  // Which speed formula the divider result feeds.
  typedef enum logic [1:0] {
    SPD_RAMP_UP,
    SPD_RAMP_DOWN,
    SPD_HOLD,
    SPD_DECEL
  } speed_mode_t;

  typedef struct packed {
    logic [15:0] peak_speed;
    logic [15:0] base_speed;
    logic [31:0] target_ticks;
    logic [30:0] fault_threshold;
    logic [23:0] decel_ticks;
    logic        invert_dir;
    logic        sensor_active_level;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic setup;
    logic simple;
    logic mul;
    logic div_step;
    logic apply;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_math;
  } status_t;

  typedef struct packed {
    logic        step_pin;
    logic        dir_pin;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  outcome;
    logic [31:0] toggle_count;
    logic [31:0] time_to_sensor;
  } res_t;

endpackage

`default_nettype wire

// ----- design/stmts_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// stmts_cfg_regs
// Configuration register file, written through the index/data channel.
// ----------------------------------------------------------------------------
`default_nettype none

module stmts_cfg_regs (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  output stmts_pkg::cfg_t          cfg
);
  import stmts_pkg::*;

  // Writes are taken in every cycle outside reset.
  assign cfg_ready = !rst;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_speed          <= 16'd1000;
      cfg.base_speed          <= 16'd200;
      cfg.target_ticks        <= 32'd1000000;
      cfg.fault_threshold     <= 31'd100000;
      cfg.decel_ticks         <= 24'd100000;
      cfg.invert_dir          <= 1'b0;
      cfg.sensor_active_level <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PEAK_SPEED:   cfg.peak_speed          <= cfg_data[15:0];
        REG_BASE_SPEED:   cfg.base_speed          <= cfg_data[15:0];
        REG_TARGET_TICKS: cfg.target_ticks        <= cfg_data;
        REG_FAULT_THRESH: cfg.fault_threshold     <= cfg_data[30:0];
        REG_DECEL_TICKS:  cfg.decel_ticks         <= cfg_data[23:0];
        REG_INVERT_DIR:   cfg.invert_dir          <= cfg_data[0];
        REG_SENSOR_LEVEL: cfg.sensor_active_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/stmts_ctrl.sv -----
// ----------------------------------------------------------------------------
// stmts_ctrl
// Controller: sequences one tick request through evaluation, the ramp
// multiply and divide when the datapath asks for them, and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module stmts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire stmts_pkg::status_t status,
  output stmts_pkg::cmd_t        cmd
);
  import stmts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_OUT
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] div_cnt;

  // State, handshake flags and divider step count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b0;
      m_tvalid <= 1'b0;
      div_cnt  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            s_tready <= 1'b0;
            state    <= ST_EVAL;
          end else begin
            s_tready <= 1'b1;
          end
        end
        ST_EVAL: begin
          if (status.need_math) begin
            state <= ST_MUL;
          end else begin
            m_tvalid <= 1'b1;
            state    <= ST_OUT;
          end
        end
        ST_MUL: begin
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          m_tvalid <= 1'b1;
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            s_tready <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath commands decoded from the state.
  always_comb begin
    cmd          = '0;
    cmd.latch    = (state == ST_IDLE) && s_tvalid && s_tready;
    cmd.setup    = (state == ST_EVAL) && status.need_math;
    cmd.simple   = (state == ST_EVAL) && !status.need_math;
    cmd.mul      = (state == ST_MUL);
    cmd.div_step = (state == ST_DIV);
    cmd.apply    = (state == ST_APPLY);
  end

`ifndef SYNTHESIS
  // Input and output sides are never open at the same time.
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("ready and valid both high");

  // At most one datapath command per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("several datapath commands at once");

  // An applied update is presented as a result next cycle.
  a_apply_out: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> m_tvalid) else $error("applied update not presented");

  // A request accepted closes the input side.
  a_accept_close: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> !s_tready) else $error("input side left open");
`endif

endmodule

`default_nettype wire

// ----- design/stmts_datapath.sv -----
// ----------------------------------------------------------------------------
// stmts_datapath
// Move state, ramp speed multiply and shared restoring divider, phase
// accumulator and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module stmts_datapath #(
  parameter int unsigned TICK_HZ = 1000000
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [3:0]    in_bits,
  input  wire stmts_pkg::cfg_t cfg,
  input  wire stmts_pkg::cmd_t cmd,
  output stmts_pkg::status_t status,
  output stmts_pkg::res_t    res
);
  import stmts_pkg::*;

  localparam logic [ACC_W-1:0] TickHz = ACC_W'(TICK_HZ);

  // Move state.
  move_phase_t      move_phase;
  logic             step_level;
  logic             dir_level;
  logic [ACC_W-1:0] phase_acc;
  logic [31:0]      elapsed_ticks;
  logic [31:0]      toggles;
  logic [15:0]      held_speed;
  logic [23:0]      decel_elapsed;
  logic [31:0]      sensor_time;

  // Latched request fields.
  logic in_start, in_ccw, in_sensor, in_abort;

  // Result registers that are not plain state.
  logic        res_done;
  logic [1:0]  res_outcome;
  logic [31:0] res_tts;

  // Arithmetic registers.
  speed_mode_t mode;
  logic        diff_neg;
  logic [15:0] op_a;
  logic [31:0] op_b;
  logic [31:0] den;
  logic [31:0] rem;
  logic [15:0] low;
  logic [15:0] quo;

  // Branch decode for the latched request.
  logic sensor_hit, decel_end;
  assign sensor_hit = (in_sensor == cfg.sensor_active_level);
  assign decel_end  = in_abort || (decel_elapsed >= cfg.decel_ticks);

  always_comb begin
    case (move_phase)
      PH_RUN:   status.need_math = !sensor_hit && !in_abort;
      PH_DECEL: status.need_math = !decel_end;
      default:  status.need_math = 1'b0;
    endcase
  end

  // Ramp operand selection.
  logic [32:0] e2;
  logic [32:0] e2_minus_t;
  logic [15:0] diff_mag;
  logic        peak_below;
  assign e2         = {elapsed_ticks, 1'b0};
  assign e2_minus_t = e2 - {1'b0, cfg.target_ticks};
  assign peak_below = (cfg.peak_speed < cfg.base_speed);
  assign diff_mag   = peak_below ? (cfg.base_speed - cfg.peak_speed)
                                 : (cfg.peak_speed - cfg.base_speed);

  // Divider step: one quotient bit per cycle.
  logic [32:0] trial;
  assign trial = {rem, low[15]} - {1'b0, den};

  // Speed from the quotient, then the accumulator update.
  logic [16:0]      sp_wide;
  logic [15:0]      speed;
  logic [ACC_W-1:0] acc_sum, acc_resid, acc_new;
  logic             due;
  logic [31:0]      tog_inc;

  always_comb begin
    case (mode)
      SPD_RAMP_UP:   sp_wide = diff_neg ? ({1'b0, cfg.base_speed} - {1'b0, quo})
                                        : ({1'b0, cfg.base_speed} + {1'b0, quo});
      SPD_RAMP_DOWN: sp_wide = diff_neg ? ({1'b0, cfg.peak_speed} + {1'b0, quo})
                                        : ({1'b0, cfg.peak_speed} - {1'b0, quo});
      SPD_DECEL:     sp_wide = (quo == 16'd0) ? 17'd1 : {1'b0, quo};
      default:       sp_wide = {1'b0, cfg.base_speed};
    endcase
    speed     = sp_wide[15:0];
    acc_sum   = phase_acc + {{(ACC_W-17){1'b0}}, speed, 1'b0};
    due       = (acc_sum >= TickHz);
    acc_resid = acc_sum - TickHz;
    if (!due) begin
      acc_new = acc_sum;
    end else if (acc_resid >= TickHz) begin
      acc_new = TickHz - 1'b1;
    end else begin
      acc_new = acc_resid;
    end
    tog_inc = toggles + 1'b1;
  end

  // Request latch and arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_start  <= in_bits[0];
      in_ccw    <= in_bits[1];
      in_sensor <= in_bits[2];
      in_abort  <= in_bits[3];
    end
    if (cmd.setup) begin
      diff_neg <= peak_below;
      if (move_phase == PH_DECEL) begin
        mode <= SPD_DECEL;
        op_a <= held_speed;
        op_b <= {8'd0, cfg.decel_ticks - decel_elapsed};
        den  <= {8'd0, cfg.decel_ticks};
      end else if (e2 < {1'b0, cfg.target_ticks}) begin
        mode <= SPD_RAMP_UP;
        op_a <= diff_mag;
        op_b <= e2[31:0];
        den  <= cfg.target_ticks;
      end else if (elapsed_ticks < cfg.target_ticks) begin
        mode <= SPD_RAMP_DOWN;
        op_a <= diff_mag;
        op_b <= e2_minus_t[31:0];
        den  <= cfg.target_ticks;
      end else begin
        mode <= SPD_HOLD;
        op_a <= 16'd0;
        op_b <= 32'd0;
        den  <= cfg.target_ticks;
      end
    end
    if (cmd.mul) begin
      {rem, low} <= op_a * op_b;
      quo        <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= {rem[30:0], low[15]};
        quo <= {quo[14:0], 1'b0};
      end
      low <= {low[14:0], 1'b0};
    end
  end

  // Move state and per-tick results.
  always_ff @(posedge clk) begin
    if (rst) begin
      move_phase    <= PH_IDLE;
      step_level    <= 1'b0;
      dir_level     <= 1'b0;
      phase_acc     <= '0;
      elapsed_ticks <= '0;
      toggles       <= '0;
      held_speed    <= '0;
      decel_elapsed <= '0;
      sensor_time   <= '0;
      res_done      <= 1'b0;
      res_outcome   <= OUTCOME_SUCCESS;
      res_tts       <= '0;
    end else if (cmd.simple) begin
      res_done    <= 1'b0;
      res_outcome <= OUTCOME_SUCCESS;
      res_tts     <= '0;
      case (move_phase)
        PH_IDLE: begin
          if (in_start) begin
            dir_level     <= ~(cfg.invert_dir ^ in_ccw);
            step_level    <= 1'b0;
            phase_acc     <= '0;
            elapsed_ticks <= '0;
            toggles       <= '0;
            held_speed    <= cfg.base_speed;
            decel_elapsed <= '0;
            sensor_time   <= '0;
            move_phase    <= PH_RUN;
          end
        end
        PH_RUN: begin
          if (sensor_hit) begin
            sensor_time   <= elapsed_ticks;
            decel_elapsed <= '0;
            move_phase    <= PH_DECEL;
          end else begin
            step_level  <= 1'b0;
            move_phase  <= PH_IDLE;
            res_done    <= 1'b1;
            res_outcome <= OUTCOME_ABORTED;
          end
        end
        PH_DECEL: begin
          step_level <= 1'b0;
          move_phase <= PH_IDLE;
          res_done   <= 1'b1;
          res_tts    <= sensor_time;
        end
        default: move_phase <= PH_IDLE;
      endcase
    end else if (cmd.apply) begin
      res_done    <= 1'b0;
      res_outcome <= OUTCOME_SUCCESS;
      res_tts     <= '0;
      phase_acc   <= acc_new;
      if (move_phase == PH_DECEL) begin
        if (due) begin
          step_level <= ~step_level;
        end
        decel_elapsed <= decel_elapsed + 1'b1;
      end else begin
        held_speed <= speed;
        if (due) begin
          toggles <= tog_inc;
          if (tog_inc > {1'b0, cfg.fault_threshold}) begin
            step_level  <= 1'b0;
            move_phase  <= PH_IDLE;
            res_done    <= 1'b1;
            res_outcome <= OUTCOME_FAULT;
          end else begin
            step_level <= ~step_level;
          end
        end
        if (elapsed_ticks != 32'hFFFF_FFFF) begin
          elapsed_ticks <= elapsed_ticks + 1'b1;
        end
      end
    end
  end

  // Result fields.
  always_comb begin
    res.step_pin       = step_level;
    res.dir_pin        = dir_level;
    res.busy_res       = (move_phase != PH_IDLE);
    res.done_res       = res_done;
    res.outcome        = res_outcome;
    res.toggle_count   = toggles;
    res.time_to_sensor = res_tts;
  end

`ifndef SYNTHESIS
  // The accumulator never holds a full period.
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    phase_acc < TickHz) else $error("phase accumulator out of range");

  // A finished move always leaves the step pin low.
  a_done_low: assert property (@(posedge clk) disable iff (rst)
    res_done |-> (!step_level && move_phase == PH_IDLE))
    else $error("finished move left pin high or busy");

  // The divider remainder stays below the divisor during a ramp.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && mode != SPD_HOLD) |-> (rem < den))
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

// ----- design/stepper_triangle_move_to_sensor_core.sv -----
// ----------------------------------------------------------------------------
// stepper_triangle_move_to_sensor_core
// Step-pulse generator with a triangle speed ramp that runs until a stop
// sensor trips, then decelerates to a halt.
// ----------------------------------------------------------------------------
// Each request is one time-base tick and yields exactly one result. A tick
// that leaves the motor still, or only starts, ends or switches the move,
// goes from evaluation straight to the result; a tick that moves the motor
// passes through evaluation, the multiply, the 16 steps of the shared
// restoring divider that forms the ramp speed and the apply step. One
// request is in work at a time; the next is taken in the cycle after the
// result is taken. Configuration writes are accepted in every cycle outside
// reset and act at once.
`default_nettype none

module stepper_triangle_move_to_sensor_core #(
  parameter int unsigned TICK_HZ = 1000000
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Tick requests.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // start_req, direction_ccw, sensor_level, abort
  // Tick results.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // step_pin, dir_pin, busy_res, done_res,
                                      // outcome[1:0], toggle_count[31:0],
                                      // time_to_sensor[31:0], zero fill
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import stmts_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  res_t    res;

  stmts_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  stmts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  stmts_datapath #(
    .TICK_HZ (TICK_HZ)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_bits (s_tdata[3:0]),
    .cfg     (cfg),
    .cmd     (cmd),
    .status  (status),
    .res     (res)
  );

  // Pack the result, first field in the lowest bit.
  assign m_tdata = {2'b00, res.time_to_sensor, res.toggle_count, res.outcome,
                    res.done_res, res.busy_res, res.dir_pin, res.step_pin};

endmodule

`default_nettype wire
